/* hw/rtl/window_max_breakout_detector_macros.svh */
// assertion macros shared by the breakout detector rtl
// no dependencies; included inside module bodies
`ifndef WINDOW_MAX_BREAKOUT_DETECTOR_MACROS_SVH
`define WINDOW_MAX_BREAKOUT_DETECTOR_MACROS_SVH

// clocked check, masked while reset is high
`define WMBD_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// clocked check that also holds during reset
`define WMBD_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* hw/rtl/wmbd_pkg.sv */
// shared types and constants of the window max breakout detector
// no dependencies
package wmbd_pkg;

   // default sizing of the top level
   localparam int DEF_MAX_WINDOW = 64;
   localparam int DEF_PRICE_BITS = 32;

   // field widths on the stream ports
   localparam int PRICE_FIELD_BITS = 32;
   localparam int CODE_BITS        = 2;
   localparam int REQ_TDATA_BITS   = 64;
   localparam int RSP_TDATA_BITS   = 40;
   localparam int RSP_PAD_BITS     = RSP_TDATA_BITS - CODE_BITS - PRICE_FIELD_BITS;

   // configuration registers
   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS  = 16;
   localparam int WINLEN_BITS    = 7;
   localparam int DIVISOR_BITS   = 16;

   localparam logic [CSR_INDEX_BITS-1:0] REG_WINDOW_LENGTH  = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_MARGIN_DIVISOR = 1'b1;

   localparam logic [WINLEN_BITS-1:0]  WINLEN_RESET  = 7'd20;
   localparam logic [DIVISOR_BITS-1:0] DIVISOR_RESET = 16'd10;

   // result codes
   typedef enum logic [CODE_BITS-1:0] {
      SIG_NONE  = 2'd0,
      SIG_LONG  = 2'd1,
      SIG_SHORT = 2'd2
   } signal_code_type;

   // request sequencer states
   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_SCAN  = 5'b00010,
      ST_DRAIN = 5'b00100,
      ST_MUL   = 5'b01000,
      ST_CMP   = 5'b10000
   } state_type;

endpackage

/* hw/rtl/wmbd_ram.sv */
// generic single write, single read ram with a registered read port
// no dependencies
module wmbd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port, registered
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/window_max_breakout_detector.sv */
// window max breakout detector: per bar, max body over the previous window and trigger test
// full history: ST_SCAN reads the window through the single read port of the body ring,
// one stored body per cycle, then ST_DRAIN, ST_MUL, ST_CMP; with short history ST_IDLE
// goes to ST_MUL directly; a new request is taken only in ST_IDLE, after ST_CMP is done
// reset: synchronous, clears bar count, ring pointer, rsp_tvalid and reloads csr defaults;
// the body ring is not cleared, entries are only read after they were written
module window_max_breakout_detector #(
   parameter int MAX_WINDOW = wmbd_pkg::DEF_MAX_WINDOW,
   parameter int PRICE_BITS = wmbd_pkg::DEF_PRICE_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   // request: [31:0] open_price, [63:32] close_price
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [wmbd_pkg::REQ_TDATA_BITS-1:0] req_tdata,
   // result: [1:0] signal_code, [33:2] window_peak, [39:34] zero
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [wmbd_pkg::RSP_TDATA_BITS-1:0] rsp_tdata,
   // configuration write port
   input  logic                                csr_we,
   input  logic [wmbd_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [wmbd_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);

   import wmbd_pkg::*;

`include "window_max_breakout_detector_macros.svh"

   localparam int PTR_BITS = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int CNT_BITS = $clog2(MAX_WINDOW + 1);
   localparam int PA_BITS  = PRICE_BITS + DIVISOR_BITS;
   localparam int PB_BITS  = PRICE_BITS + DIVISOR_BITS + 1;

   // configuration registers
   logic [WINLEN_BITS-1:0]  winlen_ff;
   logic [DIVISOR_BITS-1:0] divisor_ff;

   // control state
   state_type               state_ff, state_in;
   logic [PTR_BITS-1:0]     ptr_ff, ptr_in;
   logic [CNT_BITS-1:0]     bars_ff, bars_in;
   logic [CNT_BITS-1:0]     cnt_ff, cnt_in;
   logic [PTR_BITS-1:0]     scan_addr_ff, scan_addr_in;
   logic                    rd_pending_ff;
   logic                    rsp_tvalid_ff;

   // payload
   logic [PRICE_BITS-1:0]   body_ff, body_in;
   logic                    up_ff, down_ff;
   logic [PRICE_BITS-1:0]   peak_ff, peak_in;
   logic [PA_BITS-1:0]      prod_a_ff;
   logic [PB_BITS-1:0]      prod_b_ff;
   signal_code_type         rsp_code_ff, code_in;
   logic [PRICE_BITS-1:0]   rsp_peak_ff;

   logic [PRICE_BITS-1:0]       open_px, close_px;
   logic [PRICE_FIELD_BITS-1:0] peak_field;
   logic [CNT_BITS-1:0]         win;
   logic                        enough;
   logic                        req_fire;
   logic                        out_free;
   logic                        cmp_done;
   logic                        ram_re;
   logic [PRICE_BITS-1:0]       ram_rd_data;
   logic [DIVISOR_BITS:0]       divisor_p1;

   // price width adaption between fields and datapath
   if (PRICE_BITS > PRICE_FIELD_BITS) begin : g_wide
      assign open_px    = {{(PRICE_BITS-PRICE_FIELD_BITS){1'b0}},
                           req_tdata[PRICE_FIELD_BITS-1:0]};
      assign close_px   = {{(PRICE_BITS-PRICE_FIELD_BITS){1'b0}},
                           req_tdata[2*PRICE_FIELD_BITS-1:PRICE_FIELD_BITS]};
      assign peak_field = rsp_peak_ff[PRICE_FIELD_BITS-1:0];
   end else if (PRICE_BITS == PRICE_FIELD_BITS) begin : g_same
      assign open_px    = req_tdata[PRICE_FIELD_BITS-1:0];
      assign close_px   = req_tdata[2*PRICE_FIELD_BITS-1:PRICE_FIELD_BITS];
      assign peak_field = rsp_peak_ff;
   end else begin : g_narrow
      assign open_px    = req_tdata[PRICE_BITS-1:0];
      assign close_px   = req_tdata[PRICE_FIELD_BITS+PRICE_BITS-1:PRICE_FIELD_BITS];
      assign peak_field = {{(PRICE_FIELD_BITS-PRICE_BITS){1'b0}}, rsp_peak_ff};
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         winlen_ff  <= WINLEN_RESET;
         divisor_ff <= DIVISOR_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_WINDOW_LENGTH:  winlen_ff  <= csr_wdata[WINLEN_BITS-1:0];
            REG_MARGIN_DIVISOR: divisor_ff <= csr_wdata[DIVISOR_BITS-1:0];
            default: ;
         endcase
      end
   end

   // effective window, clamped to 1..MAX_WINDOW
   always_comb begin
      if (winlen_ff == '0) begin
         win = CNT_BITS'(1);
      end else if (32'(winlen_ff) > 32'(MAX_WINDOW)) begin
         win = CNT_BITS'(MAX_WINDOW);
      end else begin
         win = CNT_BITS'(winlen_ff);
      end
   end

   assign enough     = (bars_ff >= win);
   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_tvalid_ff || rsp_tready;
   assign cmp_done   = (state_ff == ST_CMP) && out_free;
   assign ram_re     = (state_ff == ST_SCAN);
   assign divisor_p1 = {1'b0, divisor_ff} + (DIVISOR_BITS+1)'(1);

   // body ring
   wmbd_ram #(
      .WIDTH (PRICE_BITS),
      .DEPTH (MAX_WINDOW)
   ) u_body_ring (
      .clock   (clock),
      .wr_en   (cmp_done),
      .wr_addr (ptr_ff),
      .wr_data (body_ff),
      .rd_en   (ram_re),
      .rd_addr (scan_addr_ff),
      .rd_data (ram_rd_data)
   );

   // sequencer and datapath next values
   always_comb begin
      state_in     = state_ff;
      ptr_in       = ptr_ff;
      bars_in      = bars_ff;
      cnt_in       = cnt_ff;
      scan_addr_in = scan_addr_ff;
      body_in      = body_ff;
      peak_in      = peak_ff;

      // running max over read data
      if (rd_pending_ff && (ram_rd_data > peak_ff)) begin
         peak_in = ram_rd_data;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               body_in      = (close_px > open_px) ? (close_px - open_px)
                                                   : (open_px - close_px);
               peak_in      = '0;
               cnt_in       = '0;
               scan_addr_in = (ptr_ff == '0) ? PTR_BITS'(MAX_WINDOW - 1)
                                             : ptr_ff - PTR_BITS'(1);
               state_in     = enough ? ST_SCAN : ST_MUL;
            end
         end
         ST_SCAN: begin
            cnt_in       = cnt_ff + CNT_BITS'(1);
            scan_addr_in = (scan_addr_ff == '0) ? PTR_BITS'(MAX_WINDOW - 1)
                                                : scan_addr_ff - PTR_BITS'(1);
            if (cnt_ff == win - CNT_BITS'(1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_MUL;
         end
         ST_MUL: begin
            state_in = ST_CMP;
         end
         ST_CMP: begin
            if (out_free) begin
               ptr_in   = (ptr_ff == PTR_BITS'(MAX_WINDOW - 1)) ? '0
                                                                : ptr_ff + PTR_BITS'(1);
               bars_in  = (bars_ff == CNT_BITS'(MAX_WINDOW)) ? bars_ff
                                                             : bars_ff + CNT_BITS'(1);
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // trigger test on registered products
   always_comb begin
      code_in = SIG_NONE;
      if ((peak_ff != '0) && ({1'b0, prod_a_ff} > prod_b_ff)) begin
         if (up_ff) begin
            code_in = SIG_LONG;
         end else if (down_ff) begin
            code_in = SIG_SHORT;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         ptr_ff        <= '0;
         bars_ff       <= '0;
         cnt_ff        <= '0;
         rd_pending_ff <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         ptr_ff        <= ptr_in;
         bars_ff       <= bars_in;
         cnt_ff        <= cnt_in;
         rd_pending_ff <= ram_re;
         if (cmp_done) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      body_ff      <= body_in;
      peak_ff      <= peak_in;
      scan_addr_ff <= scan_addr_in;
      if (req_fire) begin
         up_ff   <= (close_px > open_px);
         down_ff <= (close_px < open_px);
      end
      prod_a_ff <= body_ff * divisor_ff;
      prod_b_ff <= peak_ff * divisor_p1;
      if (cmp_done) begin
         rsp_code_ff <= code_in;
         rsp_peak_ff <= peak_ff;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {{RSP_PAD_BITS{1'b0}}, peak_field, rsp_code_ff};

   // checks
   `WMBD_ASSERT(a_no_rw_overlap, clock, reset, !(cmp_done && ram_re), "ring read and write overlap")
   `WMBD_ASSERT(a_scan_in_window, clock, reset, (state_ff != ST_SCAN) || (cnt_ff < win), "scan ran past window")
   `WMBD_ASSERT(a_short_skips_scan, clock, reset, (req_fire && !enough) |=> (state_ff == ST_MUL), "short history did not skip scan")
   `WMBD_ASSERT(a_code_needs_peak, clock, reset, (rsp_tvalid_ff && (rsp_code_ff != SIG_NONE)) |-> (rsp_peak_ff != '0), "breakout with zero peak")
   `WMBD_ASSERT_ALWAYS(a_bars_bounded, clock, reset || (32'(bars_ff) <= 32'(MAX_WINDOW)), "bar count above window depth")

endmodule
